/* rtl/olsr_pkg.sv */
package olsr_pkg;

  // List geometry
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int COUNT_W     = $clog2(CAPACITY + 1);

  // Request kinds
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Request beat
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] item_value;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
  } result_t;

  // Entry memory port requests from the controller
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } ram_req_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

/* rtl/olsr_ram.sv */
module olsr_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/olsr_ctrl.sv */
module olsr_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  olsr_pkg::req_t                 req,
  output logic                           done,
  output olsr_pkg::result_t              result,
  output olsr_pkg::ram_req_t             ram_req,
  input  logic [olsr_pkg::VALUE_WIDTH-1:0] ram_rdata
);

  olsr_pkg::state_t                  state, state_next;
  logic [olsr_pkg::COUNT_W-1:0]      count, count_next;
  logic [olsr_pkg::COUNT_W-1:0]      rd_idx, rd_idx_next;
  logic                              pend, pend_next;
  logic [olsr_pkg::ADDR_W-1:0]       pend_addr, pend_addr_next;
  logic [1:0]                        op, op_next;
  logic [olsr_pkg::VALUE_WIDTH-1:0]  value, value_next;
  logic                              done_next;
  olsr_pkg::result_t                 result_next;
  logic                              more;

  assign busy = (state != olsr_pkg::S_IDLE);
  assign more = (rd_idx < count);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olsr_pkg::S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx    <= rd_idx_next;
    pend_addr <= pend_addr_next;
    op        <= op_next;
    value     <= value_next;
    result    <= result_next;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_next         = state;
    count_next         = count;
    rd_idx_next        = rd_idx;
    pend_next          = 1'b0;
    pend_addr_next     = pend_addr;
    op_next            = op;
    value_next         = value;
    done_next          = 1'b0;
    result_next.status = result.status;
    ram_req            = '0;
    ram_req.wdata      = value;

    unique case (state)
      olsr_pkg::S_IDLE: begin
        if (start) begin
          value_next  = req.item_value[olsr_pkg::VALUE_WIDTH-1:0];
          op_next     = req.action;
          rd_idx_next = '0;
          unique case (req.action)
            olsr_pkg::ACT_APPEND: begin
              done_next = 1'b1;
              if (count >= olsr_pkg::COUNT_W'(olsr_pkg::CAPACITY)) begin
                result_next.status = olsr_pkg::STAT_FULL;
              end else begin
                // append straight into the tail slot
                ram_req.we         = 1'b1;
                ram_req.waddr      = count[olsr_pkg::ADDR_W-1:0];
                ram_req.wdata      = req.item_value[olsr_pkg::VALUE_WIDTH-1:0];
                count_next         = count + olsr_pkg::COUNT_W'(1);
                result_next.status = olsr_pkg::STAT_OK;
              end
            end
            olsr_pkg::ACT_SEARCH, olsr_pkg::ACT_REMOVE: begin
              state_next = olsr_pkg::S_SCAN;
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = olsr_pkg::STAT_MISS;
            end
          endcase
        end
      end

      olsr_pkg::S_SCAN: begin
        // read one entry a cycle, compare it the cycle after
        if (pend && (ram_rdata == value)) begin
          if (op == olsr_pkg::ACT_REMOVE) begin
            state_next  = olsr_pkg::S_SHIFT;
            rd_idx_next = olsr_pkg::COUNT_W'({1'b0, pend_addr}) + olsr_pkg::COUNT_W'(1);
          end else begin
            state_next         = olsr_pkg::S_IDLE;
            done_next          = 1'b1;
            result_next.status = olsr_pkg::STAT_OK;
          end
        end else if (more) begin
          ram_req.re     = 1'b1;
          ram_req.raddr  = rd_idx[olsr_pkg::ADDR_W-1:0];
          rd_idx_next    = rd_idx + olsr_pkg::COUNT_W'(1);
          pend_next      = 1'b1;
          pend_addr_next = rd_idx[olsr_pkg::ADDR_W-1:0];
        end else if (!pend) begin
          state_next         = olsr_pkg::S_IDLE;
          done_next          = 1'b1;
          result_next.status = olsr_pkg::STAT_MISS;
        end
      end

      olsr_pkg::S_SHIFT: begin
        // read entry i+1, write it to slot i once its registered read data is back
        if (pend) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_addr;
          ram_req.wdata = ram_rdata;
        end
        if (more) begin
          ram_req.re     = 1'b1;
          ram_req.raddr  = rd_idx[olsr_pkg::ADDR_W-1:0];
          rd_idx_next    = rd_idx + olsr_pkg::COUNT_W'(1);
          pend_next      = 1'b1;
          pend_addr_next = rd_idx[olsr_pkg::ADDR_W-1:0] - olsr_pkg::ADDR_W'(1);
        end else if (!pend) begin
          state_next         = olsr_pkg::S_IDLE;
          count_next         = count - olsr_pkg::COUNT_W'(1);
          done_next          = 1'b1;
          result_next.status = olsr_pkg::STAT_OK;
        end
      end

      default: begin
        state_next = olsr_pkg::S_IDLE;
      end
    endcase

    result_next.entry_count = count_next;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olsr_pkg::COUNT_W'(olsr_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> done)
    else $error("entry count changed without a result");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during a scan or shift");

  a_pend_only_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> busy)
    else $error("pending read left over in idle");

endmodule

/* rtl/ordered_list_search_remove_top.sv */
// Channel  | Ports                     | Beat
// ---------+---------------------------+----------------------------------
// request  | start, busy, req          | accepted when start && !busy
// result   | done, result              | one cycle, taken when done is high
//
// Append and unknown requests answer in the cycle after acceptance.
// Search reads entries from the oldest and answers at the first match or
// after the last entry, one entry memory read a cycle.
// Remove scans to the match at p, then moves count-p-1 entries down, one
// read and one write a cycle.
// Synchronous reset empties the list; no clearing pass is needed.
// The receiver cannot stall; busy holds requests off during a scan or shift.
module ordered_list_search_remove_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  olsr_pkg::req_t    req,
  output logic              done,
  output olsr_pkg::result_t result
);

  olsr_pkg::ram_req_t               ram_req;
  logic [olsr_pkg::VALUE_WIDTH-1:0] ram_rdata;

  olsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  olsr_ram #(
    .DEPTH (olsr_pkg::CAPACITY),
    .WIDTH (olsr_pkg::VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* tb/tb_ordered_list_search_remove_top.sv */
module tb_ordered_list_search_remove_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused request code: the block must answer a miss and leave the list alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 3;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int TAIL_CYCLES     = 2 * olsr_pkg::CAPACITY + 8;

  // Sender idle percentage per phase
  localparam int IDLE_PCT [NUM_PHASES] = '{0, 78, 6};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  olsr_pkg::req_t    req;
  logic              done;
  olsr_pkg::result_t result;

  ordered_list_search_remove_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Directed rows; typed answers only where they are obvious
  typedef struct {
    logic [1:0]        action;
    logic [31:0]       value;
    bit                typed;
    olsr_pkg::result_t exp;
  } dir_row_t;

  dir_row_t directed_rows [22] = '{
    '{olsr_pkg::ACT_SEARCH, 32'h0000_0000, 1'b1, '{olsr_pkg::STAT_MISS, 7'd0}},  // empty
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0000, 1'b1, '{olsr_pkg::STAT_MISS, 7'd0}},
    '{ACT_UNUSED,           32'hFFFF_FFFF, 1'b1, '{olsr_pkg::STAT_MISS, 7'd0}},
    '{olsr_pkg::ACT_APPEND, 32'h0000_0000, 1'b1, '{olsr_pkg::STAT_OK,   7'd1}},
    '{olsr_pkg::ACT_APPEND, 32'hFFFF_FFFF, 1'b1, '{olsr_pkg::STAT_OK,   7'd2}},
    '{olsr_pkg::ACT_SEARCH, 32'h0000_0000, 1'b1, '{olsr_pkg::STAT_OK,   7'd2}},
    '{olsr_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 1'b1, '{olsr_pkg::STAT_OK,   7'd2}},
    '{olsr_pkg::ACT_SEARCH, 32'h8000_0000, 1'b1, '{olsr_pkg::STAT_MISS, 7'd2}},
    '{olsr_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, '{olsr_pkg::STAT_OK,   7'd1}},
    '{olsr_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, '{olsr_pkg::STAT_MISS, 7'd1}},
    '{olsr_pkg::ACT_APPEND, 32'h0000_0005, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_APPEND, 32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_APPEND, 32'h0000_0005, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_APPEND, 32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0005, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},  // first dup
    '{olsr_pkg::ACT_SEARCH, 32'h0000_0005, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_SEARCH, 32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0000, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{ACT_UNUSED,           32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0007, 1'b0, '{olsr_pkg::STAT_OK,   7'd0}},
    '{olsr_pkg::ACT_REMOVE, 32'h0000_0007, 1'b1, '{olsr_pkg::STAT_MISS, 7'd1}}
  };

  // Shadow copy of the list, oldest entry at index 0
  logic [olsr_pkg::VALUE_WIDTH-1:0] shadow_list [olsr_pkg::CAPACITY];
  int                               shadow_len;

  // Answers awaited from the block, oldest first
  olsr_pkg::result_t answer_q [$];

  // Typed answer travelling with the request beat
  bit                check_typed;
  olsr_pkg::result_t typed_answer;

  int errors;
  int unsigned cycles;
  int random_items;
  int burst_left;
  int n_append, n_full, n_search, n_search_hit, n_remove, n_remove_hit, n_unused;
  int peak_len;

  // Apply one request to the shadow list and return the answer it earns
  function automatic olsr_pkg::result_t apply_to_list(olsr_pkg::req_t r);
    olsr_pkg::result_t                ans;
    logic [olsr_pkg::VALUE_WIDTH-1:0] v;
    int                               pos;
    v          = r.item_value[olsr_pkg::VALUE_WIDTH-1:0];
    ans.status = olsr_pkg::STAT_MISS;
    pos        = -1;
    if (r.action == olsr_pkg::ACT_SEARCH || r.action == olsr_pkg::ACT_REMOVE) begin
      for (int i = 0; i < shadow_len; i++) begin
        if (pos < 0 && shadow_list[i] == v) pos = i;
      end
    end
    case (r.action)
      olsr_pkg::ACT_APPEND: begin
        n_append++;
        if (shadow_len >= olsr_pkg::CAPACITY) begin
          ans.status = olsr_pkg::STAT_FULL;
          n_full++;
        end else begin
          shadow_list[shadow_len] = v;
          shadow_len++;
          ans.status = olsr_pkg::STAT_OK;
        end
      end
      olsr_pkg::ACT_SEARCH: begin
        n_search++;
        if (pos >= 0) begin
          ans.status = olsr_pkg::STAT_OK;
          n_search_hit++;
        end
      end
      olsr_pkg::ACT_REMOVE: begin
        n_remove++;
        if (pos >= 0) begin
          for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
          ans.status = olsr_pkg::STAT_OK;
          n_remove_hit++;
        end
      end
      default: n_unused++;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    ans.entry_count = 7'(shadow_len);
    return ans;
  endfunction

  // Scoreboard: check the result beat, then predict any request beat taken here
  always @(posedge clk) begin : scoreboard
    olsr_pkg::result_t want;
    olsr_pkg::result_t predicted;
    if (!rst) begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no request awaiting an answer: status %0d count %0d",
                 result.status, result.entry_count);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
          if (result.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   result.entry_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_to_list(req);
        answer_q.insert(answer_q.size(), check_typed ? typed_answer : predicted);
      end
    end
  end

  // Cycle counter and watchdog
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb_ordered_list_search_remove_top: done, errors");
    $finish;
  end

  // Present one request beat and hold it until the block takes it
  task automatic send_request(input olsr_pkg::req_t r, input bit typed,
                              input olsr_pkg::result_t ans);
    start        <= 1'b1;
    req          <= r;
    check_typed  <= typed;
    typed_answer <= ans;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender idles for a random number of cycles
  task automatic pause_sender(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off until every awaited answer has come back
  task automatic wait_for_answers();
    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  // Value choice: held values at held_pct plus a small pool so hits and duplicates occur
  function automatic logic [31:0] pick_value(input int held_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < held_pct && shadow_len > 0)
      return 32'(shadow_list[$urandom_range(0, shadow_len - 1)]);
    else if (roll < held_pct + 25)
      return 32'($urandom_range(0, 7));
    else if (roll < held_pct + 35)
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    return $urandom;
  endfunction

  // One random beat with the phase's idling in front of it, unless a burst is running
  task automatic send_random(input logic [1:0] action, input int pct, input int held_pct);
    olsr_pkg::req_t    r;
    olsr_pkg::result_t none;
    none = '0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 49) == 0) burst_left = 20;
      pause_sender(pct);
    end
    if ($urandom_range(0, 99) == 0) wait_for_answers();
    r.action     = action;
    r.item_value = pick_value(held_pct);
    send_request(r, 1'b0, none);
    if (action != ACT_UNUSED) random_items++;
  endtask

  // Mixed request kind
  function automatic logic [1:0] pick_action();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return olsr_pkg::ACT_APPEND;
    if (roll < 65) return olsr_pkg::ACT_SEARCH;
    if (roll < 95) return olsr_pkg::ACT_REMOVE;
    return ACT_UNUSED;
  endfunction

  // Stimulus
  initial begin : stimulus
    olsr_pkg::req_t r;
    int             pct;
    int             guard;
    int             kind;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    check_typed  = 1'b0;
    typed_answer = '0;
    errors       = 0;
    cycles       = 0;
    random_items = 0;
    burst_left   = 0;
    shadow_len   = 0;
    peak_len     = 0;
    n_append = 0; n_full = 0; n_search = 0; n_search_hit = 0;
    n_remove = 0; n_remove_hit = 0; n_unused = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (directed_rows[i]) begin
      r.action     = directed_rows[i].action;
      r.item_value = directed_rows[i].value;
      send_request(r, directed_rows[i].typed, directed_rows[i].exp);
    end
    wait_for_answers();

    // Random part, one idling profile per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      pct = IDLE_PCT[phase];
      while (random_items < (phase + 1) * ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          // fill to capacity, then knock on the full list
          guard = 0;
          while (shadow_len < olsr_pkg::CAPACITY && guard < 2 * olsr_pkg::CAPACITY) begin
            send_random(($urandom_range(0, 9) == 0) ? olsr_pkg::ACT_SEARCH
                                                    : olsr_pkg::ACT_APPEND, pct, 20);
            guard++;
          end
          repeat ($urandom_range(1, 3)) send_random(olsr_pkg::ACT_APPEND, pct, 20);
          send_random(olsr_pkg::ACT_SEARCH, pct, 60);
        end else if (kind < 4) begin
          // drain to empty, then probe the empty list
          guard = 0;
          while (shadow_len > 0 && guard < 3 * olsr_pkg::CAPACITY) begin
            send_random(($urandom_range(0, 5) == 0) ? olsr_pkg::ACT_SEARCH
                                                    : olsr_pkg::ACT_REMOVE, pct, 85);
            guard++;
          end
          send_random(olsr_pkg::ACT_REMOVE, pct, 0);
          send_random(olsr_pkg::ACT_SEARCH, pct, 0);
        end else begin
          repeat ($urandom_range(5, 30)) send_random(pick_action(), pct, 50);
        end
      end
      wait_for_answers();
    end

    // Let any stray result beat show up before closing
    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d appends (%0d refused as full), %0d searches (%0d hits),",
             n_append, n_full, n_search, n_search_hit);
    $display("%0d removes (%0d hits), %0d unused codes; list depth peaked at %0d",
             n_remove, n_remove_hit, n_unused, peak_len);
    if (errors == 0) begin
      $display("tb_ordered_list_search_remove_top: done, clean");
    end else begin
      $display("tb_ordered_list_search_remove_top: done, errors");
    end
    $finish;
  end

endmodule
